// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the UPS charge mode controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising aclk edge, off while aresetn is low.
`define ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Checked at every rising aclk edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== src/upsbcm_pkg.sv =====
// Types and constants of the UPS charge mode controller.
`timescale 1ns / 1ps

package upsbcm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int CHANNEL_COUNT = 3;
    localparam int CFG_IDX_W     = 8;

    // Channel order inside a transaction: cell, main supply, battery.
    localparam int CH_CELL    = 0;
    localparam int CH_MAIN    = 1;
    localparam int CH_BATTERY = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;

    localparam sample_t CH_PRESET [CHANNEL_COUNT] = '{16'd4100, 16'd12000, 16'd8200};

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_TRICKLE   = 2'd1,
        MODE_DISCHARGE = 2'd2,
        MODE_CHARGE    = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CUTOFF      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_CUTOFF   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_THRESHOLD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_HYSTERESIS = 8'd3;

    localparam sample_t RST_CHARGE_CUTOFF      = 16'd8200;
    localparam sample_t RST_DISCHARGE_CUTOFF   = 16'd7500;
    localparam sample_t RST_SUPPLY_THRESHOLD   = 16'd11900;
    localparam sample_t RST_TRICKLE_HYSTERESIS = 16'd200;

endpackage

// ===== src/upsbcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module upsbcm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ups_battery_charge_mode_controller.sv =====
// Top level: moving averages of three voltage channels and the UPS charge mode FSM.
// An accepted input transaction passes the sum, average and result registers on its way to m_tdata.
// Throughput: one transaction per cycle; the pipeline stalls only on m_tready low.
// Stages: running-sum update, reciprocal multiply to the average, mode FSM + output.
// Reset (aresetn low, synchronous): histories read as presets 4100/12000/8200,
// mode idle, config registers at defaults; no clearing pass, a wrap flag covers it.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ups_battery_charge_mode_controller
    import upsbcm_pkg::*;
#(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input samples
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] cell_sample, [31:16] main_sample, [47:32] battery_sample
    input  logic [47:0]          s_tdata,

    // Results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] cell_average, [31:16] main_average, [47:32] battery_average,
    // [49:48] mode, [50] battery_enable, [51] charge_enable,
    // [52] trickle_enable, [55:53] zero
    output logic [55:0]          m_tdata,

    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    localparam int SLOT_W      = $clog2(AVERAGE_DEPTH);
    localparam int SUM_W       = SAMPLE_W + SLOT_W;
    localparam int HIST_W      = SAMPLE_W * CHANNEL_COUNT;
    // floor(sum / AVERAGE_DEPTH) = (sum * RECIP) >> RECIP_SHIFT, exact for every sum
    localparam int RECIP_SHIFT = SUM_W + SLOT_W;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(AVERAGE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    sample_t charge_cutoff_reg, discharge_cutoff_reg;
    sample_t supply_threshold_reg, trickle_hysteresis_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_cutoff_reg      <= RST_CHARGE_CUTOFF;
            discharge_cutoff_reg   <= RST_DISCHARGE_CUTOFF;
            supply_threshold_reg   <= RST_SUPPLY_THRESHOLD;
            trickle_hysteresis_reg <= RST_TRICKLE_HYSTERESIS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHARGE_CUTOFF:      charge_cutoff_reg      <= cfg_data;
                CFG_DISCHARGE_CUTOFF:   discharge_cutoff_reg   <= cfg_data;
                CFG_SUPPLY_THRESHOLD:   supply_threshold_reg   <= cfg_data;
                CFG_TRICKLE_HYSTERESIS: trickle_hysteresis_reg <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together whenever the output
    // register is free or being drained.
    // ------------------------------------------------------------------
    logic advance;
    logic accept;
    logic a_valid_reg, b_valid_reg, m_tvalid_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg  <= s_tvalid;
            b_valid_reg  <= a_valid_reg;
            m_tvalid_reg <= b_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: history write and running-sum update.
    // The RAM read is registered and addressed ahead, at the slot the next
    // transaction will overwrite, so the outgoing sample is ready on accept.
    // Until the write pointer has wrapped once, the outgoing sample reads as its preset.
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              wrapped_reg;
    logic [HIST_W-1:0] hist_rd;

    always_comb begin
        slot_next = slot_reg;
        if (accept) begin
            slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
            if (accept && slot_reg == SLOT_LAST) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    upsbcm_ram #(
        .WIDTH (HIST_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (s_tdata[HIST_W-1:0]),
        .rd_addr (slot_next),
        .rd_data (hist_rd)
    );

    logic [SUM_W-1:0] sum_reg [CHANNEL_COUNT];
    sample_t          avg_reg [CHANNEL_COUNT];

    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_ch
        localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(CH_PRESET[c] * AVERAGE_DEPTH);

        sample_t            old_sample;
        sample_t            new_sample;
        logic [SUM_W-1:0]   sum_next;
        logic [PROD_W-1:0]  prod;

        assign old_sample = wrapped_reg ? hist_rd[c*SAMPLE_W +: SAMPLE_W] : CH_PRESET[c];
        assign new_sample = s_tdata[c*SAMPLE_W +: SAMPLE_W];
        assign sum_next   = sum_reg[c] - SUM_W'(old_sample) + SUM_W'(new_sample);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sum_reg[c] <= SUM_INIT;
            end else if (accept) begin
                sum_reg[c] <= sum_next;
            end
        end

        // Stage B: average by constant reciprocal
        assign prod = PROD_W'(sum_reg[c]) * PROD_W'(RECIP);

        always_ff @(posedge aclk) begin
            if (advance) begin
                avg_reg[c] <= prod[RECIP_SHIFT +: SAMPLE_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: mode FSM on the averages, result register.
    // ------------------------------------------------------------------
    mode_t   current_mode_reg, mode_next;
    logic    mode_upd;
    logic    main_low, main_high, bat_low, bat_high, bat_trickle;
    sample_t main_avg, bat_avg;

    assign mode_upd = advance && b_valid_reg;
    assign main_avg = avg_reg[CH_MAIN];
    assign bat_avg  = avg_reg[CH_BATTERY];

    assign main_low    = main_avg < supply_threshold_reg;
    assign main_high   = main_avg > supply_threshold_reg;
    assign bat_low     = bat_avg < discharge_cutoff_reg;
    assign bat_high    = bat_avg > charge_cutoff_reg;
    // 17-bit sum: a hysteresis above the cutoff never passes
    assign bat_trickle = ({1'b0, bat_avg} + {1'b0, trickle_hysteresis_reg})
                         < {1'b0, charge_cutoff_reg};

    always_comb begin
        mode_next = current_mode_reg;
        case (current_mode_reg)
            MODE_IDLE: begin
                if (main_low)         mode_next = MODE_DISCHARGE;
                else if (bat_low)     mode_next = MODE_CHARGE;
                else if (bat_trickle) mode_next = MODE_TRICKLE;
            end
            MODE_TRICKLE: begin
                if (main_low)      mode_next = MODE_DISCHARGE;
                else if (bat_low)  mode_next = MODE_CHARGE;
                else if (bat_high) mode_next = MODE_IDLE;
            end
            MODE_DISCHARGE: begin
                if (main_high) mode_next = MODE_CHARGE;
            end
            MODE_CHARGE: begin
                if (main_low)      mode_next = MODE_DISCHARGE;
                else if (bat_high) mode_next = MODE_TRICKLE;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_mode_reg <= MODE_IDLE;
        end else if (mode_upd) begin
            current_mode_reg <= mode_next;
        end
    end

    logic [55:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (mode_upd) begin
            m_tdata_reg <= {3'b000,
                            mode_next == MODE_TRICKLE,
                            mode_next == MODE_CHARGE,
                            (mode_next == MODE_TRICKLE) || (mode_next == MODE_CHARGE),
                            mode_next,
                            avg_reg[CH_BATTERY],
                            avg_reg[CH_MAIN],
                            avg_reg[CH_CELL]};
        end
    end

    assign m_tdata = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // discharge leaves only toward charge
    `ASSERT_RST(a_discharge_exit,
        (mode_upd && current_mode_reg == MODE_DISCHARGE) |=>
        (current_mode_reg == MODE_DISCHARGE || current_mode_reg == MODE_CHARGE))
    // charge never drops straight to idle
    `ASSERT_RST(a_charge_exit,
        (mode_upd && current_mode_reg == MODE_CHARGE) |=> (current_mode_reg != MODE_IDLE))
    // once the history has been filled it stays filled
    `ASSERT_RST(a_wrap_sticky, wrapped_reg |=> wrapped_reg)
    // a visible result carries the mode the FSM now holds
    `ASSERT_RST(a_out_mode, m_tvalid_reg |-> (m_tdata_reg[49:48] == current_mode_reg))

endmodule
